### rtl/core/linear_probe_hash_table_defines.svh
// ----------------------------------------------------------------------------
// Linear probe hash table assertion macros
// Concurrent assertion helpers used by the datapath RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LPHT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LPHT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPHT_ASSERT(label, clk, rst, prop, msg)
`define LPHT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/core/lpht_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared widths, result codes, controller states and datapath operations.
// ----------------------------------------------------------------------------
`default_nettype none
package lpht_pkg;
  localparam int LPHT_DEPTH = 32;
  localparam int KEY_W      = 31;
  localparam int VAL_W      = 64;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 5;
  localparam int SIZE_W     = 6;
  localparam int MAX_RES    = 32;
  localparam int CNT_W      = $clog2(MAX_RES + 1);
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUMP_ENTRY = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DUMP_EMPTY = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_WAIT_MOD, S_ADD, S_DEL_CHK, S_DEL_CMP,
    S_REP_CHK, S_REP_SCAN, S_REP_CMP, S_DUMP_SCAN, S_DUMP_TAKE, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_HOME, OP_ADD_PUT, OP_ADD_NEXT, OP_ADD_FULL,
    OP_DEL_READ, OP_DEL_HIT, OP_DEL_NEXT, OP_DEL_MISS,
    OP_REP_INIT, OP_REP_READ, OP_REP_MOVE, OP_REP_NEXT, OP_REP_DONE,
    OP_DUMP_INIT, OP_DUMP_READ, OP_DUMP_NEXT, OP_DUMP_TAKE, OP_DUMP_EMPTY,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic mod_done;
    logic occ_i;
    logic probe_last;
    logic wrap_home;
    logic key_match;
    logic hole_next_occ;
    logic j_is_hole;
    logic occ_j;
    logic closer;
    logic dump_end;
    logic k_zero;
    logic res_last;
    logic out_free;
  } dp_status_t;
endpackage
`default_nettype wire

### rtl/core/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressed table with add, delete with hole repair, and dump.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. The home slot comes from a bit-serial
// remainder unit. After that, an add probes one slot at a time until it finds
// a free slot or has probed every slot. A delete checks each probed slot and
// reads it if occupied. The hole repair scan then reads each occupied slot
// that it visits. A dump scans the slots of the active size and reads each
// occupied one. The slot memory has a single read port. A result waits in
// an output register, so a new transaction is taken once the last result is
// loaded. Writing the size register empties the table at once.
`default_nettype none
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int TABLE_DEPTH = LPHT_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                table_size_write,
  input  wire logic [SIZE_W-1:0]   table_size,
  input  wire logic                valid,
  output logic                     stall,
  input  wire logic [MODE_W-1:0]   mode,
  input  wire logic [KEY_W-1:0]    key,
  input  wire logic [VAL_W-1:0]    value,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic [STATUS_W-1:0]      status,
  output logic [SLOT_W-1:0]        slot,
  output logic [KEY_W-1:0]         entry_key,
  output logic [VAL_W-1:0]         entry_value,
  output logic                     last
);
  op_t        op;
  dp_status_t sts;

  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (valid),
    .sts   (sts),
    .op    (op),
    .stall (stall)
  );

  lpht_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .op               (op),
    .sts              (sts),
    .mode             (mode),
    .key              (key),
    .value            (value),
    .table_size_write (table_size_write),
    .table_size       (table_size),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .status           (status),
    .slot             (slot),
    .entry_key        (entry_key),
    .entry_value      (entry_value),
    .last             (last)
  );
endmodule
`default_nettype wire

### rtl/core/lpht_mod.sv
// ----------------------------------------------------------------------------
// Linear probe hash table modulo unit
// Restoring remainder of a key by the active table size, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_mod
  import lpht_pkg::*;
#(
  parameter int NW = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [KEY_W-1:0]  dividend,
  input  wire logic [NW-1:0]     divisor,
  output logic                   done,
  output logic [NW-1:0]          rem
);
  localparam int BW = $clog2(KEY_W);

  logic [KEY_W-1:0] shreg;
  logic [BW-1:0]    cnt;
  logic             active;
  logic [NW:0]      trial;

  assign trial = {rem, shreg[KEY_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= '0;
        shreg  <= dividend;
      end else if (active) begin
        shreg <= {shreg[KEY_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem <= NW'(trial - {1'b0, divisor});
        end else begin
          rem <= NW'(trial);
        end
        cnt <= cnt + 1'b1;
        if (cnt == BW'(KEY_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/lpht_datapath.sv
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Slot storage, probe pointers, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "linear_probe_hash_table_defines.svh"
module lpht_datapath
  import lpht_pkg::*;
#(
  parameter int TABLE_DEPTH = LPHT_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire op_t                 op,
  output dp_status_t               sts,
  input  wire logic [MODE_W-1:0]   mode,
  input  wire logic [KEY_W-1:0]    key,
  input  wire logic [VAL_W-1:0]    value,
  input  wire logic                table_size_write,
  input  wire logic [SIZE_W-1:0]   table_size,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic [STATUS_W-1:0]      status,
  output logic [SLOT_W-1:0]        slot,
  output logic [KEY_W-1:0]         entry_key,
  output logic [VAL_W-1:0]         entry_value,
  output logic                     last
);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = SIZE_W + 1;

  logic [SIZE_W-1:0]      size_reg;
  logic [NW-1:0]          n_act;
  logic [SW-1:0]          size_ext;
  logic [TABLE_DEPTH-1:0] occ;
  logic [KEY_W-1:0]       key_mem [TABLE_DEPTH];
  logic [VAL_W-1:0]       val_mem [TABLE_DEPTH];
  logic [IW-1:0]          home_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]       rd_key;
  logic [VAL_W-1:0]       rd_val;
  logic [IW-1:0]          rd_home;
  logic [MODE_W-1:0]      in_mode;
  logic [KEY_W-1:0]       in_key;
  logic [VAL_W-1:0]       in_val;
  logic [NW-1:0]          i;
  logic [NW-1:0]          c;
  logic [IW-1:0]          home;
  logic [IW-1:0]          hole;
  logic [IW-1:0]          j;
  logic [IW-1:0]          found;
  logic [CNT_W-1:0]       k;
  logic [STATUS_W-1:0]    res_status;
  logic [SLOT_W-1:0]      res_slot;
  logic [KEY_W-1:0]       res_key;
  logic [VAL_W-1:0]       res_val;
  logic                   res_last;
  logic                   mod_done;
  logic [NW-1:0]          mod_rem;
  logic                   rd_en;
  logic [IW-1:0]          rd_addr;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [KEY_W-1:0]       wr_key;
  logic [VAL_W-1:0]       wr_val;
  logic [IW-1:0]          wr_home;
  logic                   any_above;
  logic                   out_free;
  logic [NW-1:0]          i_inc;
  logic [IW-1:0]          hole_inc;

  function automatic logic [NW-1:0] wrap_inc(logic [NW-1:0] x, logic [NW-1:0] n);
    return (x == n - 1'b1) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IW-1:0] wrap_dec(logic [IW-1:0] x, logic [NW-1:0] n);
    return (x == '0) ? IW'(n - 1'b1) : x - 1'b1;
  endfunction

  function automatic logic [NW:0] down_dist(logic [IW-1:0] at, logic [IW-1:0] hm,
                                            logic [NW-1:0] n);
    logic [NW:0] a;
    logic [NW:0] h;
    a = (NW+1)'(at);
    h = (NW+1)'(hm);
    return (a < h) ? a + (NW+1)'(n) - h : a - h;
  endfunction

  assign size_ext = SW'(size_reg);

  always_comb begin
    if (size_reg == '0) begin
      n_act = NW'(1);
    end else if (size_ext > SW'(TABLE_DEPTH)) begin
      n_act = NW'(TABLE_DEPTH);
    end else begin
      n_act = NW'(size_reg);
    end
  end

  lpht_mod #(.NW(NW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (op == OP_LOAD),
    .dividend (key),
    .divisor  (n_act),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign i_inc    = wrap_inc(i, n_act);
  assign hole_inc = IW'(wrap_inc(NW'(hole), n_act));
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    any_above = 1'b0;
    for (int b = 0; b < TABLE_DEPTH; b++) begin
      if (occ[b] && (NW'(b) > i) && (NW'(b) < n_act)) begin
        any_above = 1'b1;
      end
    end
  end

  always_comb begin
    sts.mode          = in_mode;
    sts.mod_done      = mod_done;
    sts.occ_i         = occ[i[IW-1:0]];
    sts.probe_last    = (c == n_act - 1'b1);
    sts.wrap_home     = (i_inc == NW'(home));
    sts.key_match     = (rd_key == in_key);
    sts.hole_next_occ = occ[hole_inc];
    sts.j_is_hole     = (j == hole);
    sts.occ_j         = occ[j];
    sts.closer        = down_dist(hole, rd_home, n_act) < down_dist(j, rd_home, n_act);
    sts.dump_end      = (i >= n_act) || (k == CNT_W'(MAX_RES));
    sts.k_zero        = (k == '0);
    sts.res_last      = res_last;
    sts.out_free      = out_free;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = i[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = i[IW-1:0];
    wr_key  = in_key;
    wr_val  = in_val;
    wr_home = home;
    case (op)
      OP_DEL_READ, OP_DUMP_READ: begin
        rd_en = 1'b1;
      end
      OP_REP_READ: begin
        rd_en   = 1'b1;
        rd_addr = j;
      end
      OP_ADD_PUT: begin
        wr_en = 1'b1;
      end
      OP_REP_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = hole;
        wr_key  = rd_key;
        wr_val  = rd_val;
        wr_home = rd_home;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      val_mem[wr_addr]  <= wr_val;
      home_mem[wr_addr] <= wr_home;
    end
    if (rd_en) begin
      rd_key  <= key_mem[rd_addr];
      rd_val  <= val_mem[rd_addr];
      rd_home <= home_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_RESET;
      occ      <= '0;
    end else if (table_size_write) begin
      size_reg <= table_size;
      occ      <= '0;
    end else begin
      case (op)
        OP_ADD_PUT:  occ[i[IW-1:0]] <= 1'b1;
        OP_DEL_HIT:  occ[i[IW-1:0]] <= 1'b0;
        OP_REP_MOVE: begin
          occ[hole] <= 1'b1;
          occ[j]    <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        in_mode <= mode;
        in_key  <= key;
        in_val  <= value;
      end
      OP_HOME: begin
        i    <= mod_rem;
        c    <= '0;
        home <= IW'(mod_rem);
      end
      OP_ADD_PUT: begin
        res_status <= ST_ADDED;
        res_slot   <= SLOT_W'(i);
        res_key    <= in_key;
        res_val    <= '0;
        res_last   <= 1'b1;
      end
      OP_ADD_NEXT: begin
        i <= i_inc;
        c <= c + 1'b1;
      end
      OP_ADD_FULL: begin
        res_status <= ST_FULL;
        res_slot   <= '0;
        res_key    <= in_key;
        res_val    <= '0;
        res_last   <= 1'b1;
      end
      OP_DEL_HIT: begin
        found <= i[IW-1:0];
        hole  <= i[IW-1:0];
      end
      OP_DEL_NEXT: begin
        i <= i_inc;
      end
      OP_DEL_MISS: begin
        res_status <= ST_NOT_FOUND;
        res_slot   <= '0;
        res_key    <= in_key;
        res_val    <= '0;
        res_last   <= 1'b1;
      end
      OP_REP_INIT: begin
        j <= wrap_dec(hole, n_act);
      end
      OP_REP_MOVE: begin
        hole <= j;
      end
      OP_REP_NEXT: begin
        j <= wrap_dec(j, n_act);
      end
      OP_REP_DONE: begin
        res_status <= ST_REMOVED;
        res_slot   <= SLOT_W'(found);
        res_key    <= in_key;
        res_val    <= '0;
        res_last   <= 1'b1;
      end
      OP_DUMP_INIT: begin
        i <= '0;
        k <= '0;
      end
      OP_DUMP_NEXT: begin
        i <= i + 1'b1;
      end
      OP_DUMP_TAKE: begin
        res_status <= ST_DUMP_ENTRY;
        res_slot   <= SLOT_W'(i);
        res_key    <= rd_key;
        res_val    <= rd_val;
        res_last   <= (k == CNT_W'(MAX_RES - 1)) || !any_above;
        k          <= k + 1'b1;
        i          <= i + 1'b1;
      end
      OP_DUMP_EMPTY: begin
        res_status <= ST_DUMP_EMPTY;
        res_slot   <= '0;
        res_key    <= '0;
        res_val    <= '0;
        res_last   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (op == OP_EMIT) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      status      <= res_status;
      slot        <= res_slot;
      entry_key   <= res_key;
      entry_value <= res_val;
      last        <= res_last;
    end
  end

  `LPHT_ASSERT(a_occ_within_size, clk, rst, ($countones(occ) <= int'(n_act)), "slots beyond size")
  `LPHT_ASSERT(a_emit_free, clk, rst, (op == OP_EMIT) |-> out_free, "result overwritten")
  `LPHT_ASSERT(a_move_ok, clk, rst, (op == OP_REP_MOVE) |-> (!occ[hole] && occ[j]), "bad move")
  `LPHT_ASSERT(a_emit_valid, clk, rst, (op == OP_EMIT) |=> result_valid, "result lost")
endmodule
`default_nettype wire

### rtl/core/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// Sequences add, delete with hole repair, and dump over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_ctrl
  import lpht_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       valid,
  input  wire dp_status_t sts,
  output op_t             op,
  output logic            stall
);
  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (valid) begin
          op         = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.mode == MODE_ADD || sts.mode == MODE_DELETE) begin
          state_next = S_WAIT_MOD;
        end else if (sts.mode == MODE_DUMP) begin
          op         = OP_DUMP_INIT;
          state_next = S_DUMP_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WAIT_MOD: begin
        if (sts.mod_done) begin
          op         = OP_HOME;
          state_next = (sts.mode == MODE_ADD) ? S_ADD : S_DEL_CHK;
        end
      end
      S_ADD: begin
        if (!sts.occ_i) begin
          op         = OP_ADD_PUT;
          state_next = S_EMIT;
        end else if (sts.probe_last) begin
          op         = OP_ADD_FULL;
          state_next = S_EMIT;
        end else begin
          op = OP_ADD_NEXT;
        end
      end
      S_DEL_CHK: begin
        if (!sts.occ_i) begin
          op         = OP_DEL_MISS;
          state_next = S_EMIT;
        end else begin
          op         = OP_DEL_READ;
          state_next = S_DEL_CMP;
        end
      end
      S_DEL_CMP: begin
        if (sts.key_match) begin
          op         = OP_DEL_HIT;
          state_next = S_REP_CHK;
        end else if (sts.wrap_home) begin
          op         = OP_DEL_MISS;
          state_next = S_EMIT;
        end else begin
          op         = OP_DEL_NEXT;
          state_next = S_DEL_CHK;
        end
      end
      S_REP_CHK: begin
        if (sts.hole_next_occ) begin
          op         = OP_REP_INIT;
          state_next = S_REP_SCAN;
        end else begin
          op         = OP_REP_DONE;
          state_next = S_EMIT;
        end
      end
      S_REP_SCAN: begin
        if (sts.j_is_hole) begin
          op         = OP_REP_DONE;
          state_next = S_EMIT;
        end else if (sts.occ_j) begin
          op         = OP_REP_READ;
          state_next = S_REP_CMP;
        end else begin
          op = OP_REP_NEXT;
        end
      end
      S_REP_CMP: begin
        if (sts.closer) begin
          op         = OP_REP_MOVE;
          state_next = S_REP_CHK;
        end else begin
          op         = OP_REP_NEXT;
          state_next = S_REP_SCAN;
        end
      end
      S_DUMP_SCAN: begin
        if (sts.dump_end) begin
          if (sts.k_zero) begin
            op         = OP_DUMP_EMPTY;
            state_next = S_EMIT;
          end else begin
            state_next = S_IDLE;
          end
        end else if (sts.occ_i) begin
          op         = OP_DUMP_READ;
          state_next = S_DUMP_TAKE;
        end else begin
          op = OP_DUMP_NEXT;
        end
      end
      S_DUMP_TAKE: begin
        op         = OP_DUMP_TAKE;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          op         = OP_EMIT;
          state_next = sts.res_last ? S_IDLE : S_DUMP_SCAN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire
